>>> sv/counting_semaphore_unit_defines.svh
// assertion macros shared by the counting semaphore unit rtl
// no dependencies; included by the files that carry assertions
`ifndef COUNTING_SEMAPHORE_UNIT_DEFINES_SVH
`define COUNTING_SEMAPHORE_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CSU_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CSU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> sv/csu_pkg.sv
// shared types, constants and helpers of the counting semaphore unit
// no dependencies
package csu_pkg;

    localparam int SEM_COUNT_DEF  = 32;
    localparam int TASK_COUNT_DEF = 64;

    // field widths of the transfer payloads
    localparam int KIND_W   = 2;
    localparam int IDX_W    = 5;
    localparam int INIT_W   = 15;
    localparam int TASK_W   = 6;
    localparam int CNT_W    = 16;
    localparam int TASK_IDS = 2 ** TASK_W;

    // in-use bits examined per cycle by the allocate search
    localparam int SCAN_W = 32;

    localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;
    localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
    localparam logic signed [CNT_W-1:0] CNT_ONE = 16'sh0001;

    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_FREE   = 2'd1,
        KIND_WAIT   = 2'd2,
        KIND_SIGNAL = 2'd3
    } kind_t;

    // one entry of the semaphore memory
    typedef struct packed {
        logic signed [CNT_W-1:0] count;
        logic                    nonempty;
        logic [TASK_W-1:0]       head;
        logic [TASK_W-1:0]       tail;
    } sem_rec_t;

    // control from the sequencer to the allocation bitmap
    typedef struct packed {
        logic restart;
        logic scan;
        logic claim;
        logic free_sem;
    } alloc_cmd_t;

    // status from the allocation bitmap
    typedef struct packed {
        logic found;
        logic last;
    } alloc_stat_t;

    // decisions of the wait/signal update
    typedef struct packed {
        logic proceed;
        logic wake;
        logic need_link;
        logic link_write;
    } upd_t;

    typedef logic [TASK_IDS-1:0][TASK_W-1:0] task_lut_t;

    // task id wrap table, built by counting so no divider is needed
    function automatic task_lut_t build_task_lut(input int n);
        task_lut_t lut;
        int        r;
        r = 0;
        for (int i = 0; i < TASK_IDS; i++)
        begin
            lut[i] = TASK_W'(r);
            if (r + 1 == n)
            begin
                r = 0;
            end
            else
            begin
                r = r + 1;
            end
        end
        return lut;
    endfunction

endpackage

>>> sv/counting_semaphore_unit.sv
// counting semaphore table with fifo wait queues, top level
// depends on csu_pkg, csu_ram, csu_alloc, csu_update and the defines header
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    kind sem_index initial_count task_id
//   rsp      out        rsp_valid/rsp_ready    alloc_ok alloc_index proceed
//                                              woken_valid woken_task error
//
// free, wait and signal run in the execute state; a signal that releases a waiter
// with others still queued adds the link state (second read, of the next-waiter ram).
// allocate scans 32 in-use bits per cycle while the output register is free.
// reset clears the in-use bitmap and control; memories need no clearing pass.
// a new request is taken while a result waits in the output register; a
// finished operation holds its write-back until that register is free.
`include "counting_semaphore_unit_defines.svh"
module counting_semaphore_unit import csu_pkg::*; #(
    parameter int SEM_COUNT  = SEM_COUNT_DEF,
    parameter int TASK_COUNT = TASK_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [KIND_W-1:0] kind,
    input  logic [IDX_W-1:0]  sem_index,
    input  logic [INIT_W-1:0] initial_count,
    input  logic [TASK_W-1:0] task_id,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic              alloc_ok,
    output logic [IDX_W-1:0]  alloc_index,
    output logic              proceed,
    output logic              woken_valid,
    output logic [TASK_W-1:0] woken_task,
    output logic              error
);

    localparam int SW = $clog2(SEM_COUNT);
    localparam int TW = $clog2(TASK_COUNT);
    localparam task_lut_t TaskWrap = build_task_lut(TASK_COUNT);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_LINK = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic [IDX_W-1:0]  op_idx_reg;
    logic [INIT_W-1:0] op_init_reg;
    logic [TASK_W-1:0] op_task_reg;
    kind_t             op_kind_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              alloc_ok_reg, alloc_ok_next;
    logic [IDX_W-1:0]  alloc_index_reg, alloc_index_next;
    logic              proceed_reg, proceed_next;
    logic              woken_valid_reg, woken_valid_next;
    logic [TASK_W-1:0] woken_task_reg, woken_task_next;
    logic              error_reg, error_next;

    logic accept;
    logic out_free;
    logic res_fire;

    logic                      sem_we;
    logic [SW-1:0]             sem_waddr, sem_raddr;
    sem_rec_t                  sem_wdata, sem_rd, rec_next;
    logic [$bits(sem_rec_t)-1:0] sem_rdata_raw;

    logic              link_we;
    logic [TW-1:0]     link_waddr, link_raddr;
    logic [TASK_W-1:0] link_rdata;

    alloc_cmd_t    alloc_cmd;
    alloc_stat_t   alloc_stat;
    logic [SW-1:0] found_index;
    logic          query_used;
    upd_t          upd;

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // semaphore record memory: count, queue flag, head and tail
    csu_ram #(
        .WIDTH ($bits(sem_rec_t)),
        .DEPTH (SEM_COUNT)
    ) u_sem_ram (
        .clk   (clk),
        .we    (sem_we),
        .waddr (sem_waddr),
        .wdata (sem_wdata),
        .raddr (sem_raddr),
        .rdata (sem_rdata_raw)
    );

    assign sem_rd    = sem_rec_t'(sem_rdata_raw);
    assign sem_raddr = (state_reg == ST_IDLE) ? SW'(sem_index) : SW'(op_idx_reg);

    // next-waiter links of the wait queues
    csu_ram #(
        .WIDTH (TASK_W),
        .DEPTH (TASK_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (op_task_reg),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    assign link_waddr = TW'(sem_rd.tail);
    assign link_raddr = TW'(sem_rd.head);

    csu_alloc #(
        .SEM_COUNT (SEM_COUNT)
    ) u_alloc (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (alloc_cmd),
        .free_index  (SW'(op_idx_reg)),
        .query_index (op_idx_reg),
        .query_used  (query_used),
        .stat        (alloc_stat),
        .found_index (found_index)
    );

    csu_update u_update (
        .kind      (op_kind_reg),
        .rec       (sem_rd),
        .task_id   (op_task_reg),
        .link_head (link_rdata),
        .rec_next  (rec_next),
        .upd       (upd)
    );

    // sequencer: read, modify, write back with the result transfer
    always_comb
    begin
        state_next       = state_reg;
        res_fire         = 1'b0;
        alloc_ok_next    = 1'b0;
        alloc_index_next = '0;
        proceed_next     = 1'b0;
        woken_valid_next = 1'b0;
        woken_task_next  = '0;
        error_next       = 1'b0;
        sem_we           = 1'b0;
        sem_waddr        = SW'(op_idx_reg);
        sem_wdata        = rec_next;
        link_we          = 1'b0;
        alloc_cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    alloc_cmd.restart = 1'b1;
                    state_next        = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    unique case (op_kind_reg)
                        KIND_ALLOC:
                        begin
                            alloc_cmd.scan = 1'b1;
                            if (alloc_stat.found)
                            begin
                                alloc_cmd.claim    = 1'b1;
                                sem_we             = 1'b1;
                                sem_waddr          = found_index;
                                sem_wdata          = '0;
                                sem_wdata.count    = signed'(CNT_W'(op_init_reg));
                                alloc_ok_next      = 1'b1;
                                alloc_index_next   = IDX_W'(found_index);
                                res_fire           = 1'b1;
                                state_next         = ST_IDLE;
                            end
                            else if (alloc_stat.last)
                            begin
                                res_fire   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        KIND_FREE:
                        begin
                            alloc_cmd.free_sem = query_used;
                            res_fire           = 1'b1;
                            state_next         = ST_IDLE;
                        end
                        KIND_WAIT, KIND_SIGNAL:
                        begin
                            if (!query_used)
                            begin
                                error_next = 1'b1;
                                res_fire   = 1'b1;
                                state_next = ST_IDLE;
                            end
                            else if (upd.need_link)
                            begin
                                state_next = ST_LINK;
                            end
                            else
                            begin
                                sem_we           = 1'b1;
                                link_we          = upd.link_write;
                                proceed_next     = upd.proceed;
                                woken_valid_next = upd.wake;
                                woken_task_next  = upd.wake ? sem_rd.head : '0;
                                res_fire         = 1'b1;
                                state_next       = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_LINK:
            begin
                // head advances to the link read in the previous cycle
                if (out_free)
                begin
                    sem_we           = 1'b1;
                    woken_valid_next = 1'b1;
                    woken_task_next  = sem_rd.head;
                    res_fire         = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register occupancy
    always_comb
    begin
        if (res_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // request capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_kind_reg <= kind_t'(kind);
            op_idx_reg  <= sem_index;
            op_init_reg <= initial_count;
            op_task_reg <= TaskWrap[task_id];
        end
        if (res_fire)
        begin
            alloc_ok_reg    <= alloc_ok_next;
            alloc_index_reg <= alloc_index_next;
            proceed_reg     <= proceed_next;
            woken_valid_reg <= woken_valid_next;
            woken_task_reg  <= woken_task_next;
            error_reg       <= error_next;
        end
    end

    assign rsp_valid   = rsp_valid_reg;
    assign alloc_ok    = alloc_ok_reg;
    assign alloc_index = alloc_index_reg;
    assign proceed     = proceed_reg;
    assign woken_valid = woken_valid_reg;
    assign woken_task  = woken_task_reg;
    assign error       = error_reg;

    `CSU_ASSERT_IMPLIES(a_write_with_result, clk, rst_n, sem_we || link_we,
        res_fire && out_free, "memory write-back without a result transfer")
    `CSU_ASSERT_IMPLIES(a_link_state, clk, rst_n, state_reg == ST_LINK,
        op_kind_reg == KIND_SIGNAL && sem_rd.nonempty, "link read outside a signal release")
    `CSU_ASSERT_IMPLIES(a_link_write, clk, rst_n, link_we,
        op_kind_reg == KIND_WAIT && sem_rd.nonempty, "queue link written on an empty queue")

endmodule

>>> sv/csu_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
module csu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/csu_alloc.sv
// in-use bitmap with lowest-free search, one window of bits per cycle while scanning
// depends on csu_pkg and counting_semaphore_unit_defines.svh
`include "counting_semaphore_unit_defines.svh"
module csu_alloc import csu_pkg::*; #(
    parameter int SEM_COUNT = SEM_COUNT_DEF,
    localparam int SW       = $clog2(SEM_COUNT)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  alloc_cmd_t        cmd,
    input  logic [SW-1:0]     free_index,
    input  logic [IDX_W-1:0]  query_index,
    output logic              query_used,
    output alloc_stat_t       stat,
    output logic [SW-1:0]     found_index
);

    localparam int NCHUNK = (SEM_COUNT + SCAN_W - 1) / SCAN_W;
    localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PADW   = NCHUNK * SCAN_W;
    localparam int PW     = $clog2(SCAN_W);

    logic [SEM_COUNT-1:0] in_use_reg, in_use_next;
    logic [CHW-1:0]       chunk_reg, chunk_next;
    logic [PADW-1:0]      used_pad;
    logic [SCAN_W-1:0]    window;
    logic [PW-1:0]        pick;
    logic                 pick_ok;
    logic                 in_range;

    // pad the bitmap to whole windows, padding reads as used
    for (genvar g = 0; g < PADW; g++)
    begin : g_pad
        if (g < SEM_COUNT)
        begin : g_real
            assign used_pad[g] = in_use_reg[g];
        end
        else
        begin : g_fill
            assign used_pad[g] = 1'b1;
        end
    end

    // lowest clear bit of the current window
    always_comb
    begin
        window  = used_pad[chunk_reg * SCAN_W +: SCAN_W];
        pick_ok = 1'b0;
        pick    = '0;
        for (int j = SCAN_W - 1; j >= 0; j--)
        begin
            if (!window[j])
            begin
                pick_ok = 1'b1;
                pick    = PW'(j);
            end
        end
    end

    assign found_index = SW'({chunk_reg, pick});
    assign stat.found  = pick_ok;
    assign stat.last   = (chunk_reg == CHW'(NCHUNK - 1));

    // in-use lookup of the addressed semaphore
    assign in_range   = (32'(query_index) < SEM_COUNT);
    assign query_used = in_range && in_use_reg[SW'(query_index)];

    // bitmap and window counter updates
    always_comb
    begin
        in_use_next = in_use_reg;
        if (cmd.claim)
        begin
            in_use_next[found_index] = 1'b1;
        end
        if (cmd.free_sem)
        begin
            in_use_next[free_index] = 1'b0;
        end
        chunk_next = chunk_reg;
        if (cmd.restart)
        begin
            chunk_next = '0;
        end
        else if (cmd.scan && !pick_ok && !stat.last)
        begin
            chunk_next = chunk_reg + CHW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg <= '0;
            chunk_reg  <= '0;
        end
        else
        begin
            in_use_reg <= in_use_next;
            chunk_reg  <= chunk_next;
        end
    end

    `CSU_ASSERT_IMPLIES(a_claim_is_free, clk, rst_n, cmd.claim,
        cmd.scan && pick_ok && !in_use_reg[found_index], "claim without a free slot")
    `CSU_ASSERT_NEXT(a_claim_sets_bit, clk, rst_n, cmd.claim && !cmd.free_sem,
        in_use_reg[$past(found_index)], "claimed slot not marked in use")

endmodule

>>> sv/csu_update.sv
// count and wait-queue update for wait and signal operations
// depends on csu_pkg
module csu_update import csu_pkg::*; (
    input  kind_t             kind,
    input  sem_rec_t          rec,
    input  logic [TASK_W-1:0] task_id,
    input  logic [TASK_W-1:0] link_head,
    output sem_rec_t          rec_next,
    output upd_t              upd
);

    logic signed [CNT_W-1:0] cnt;

    always_comb
    begin
        rec_next = rec;
        upd      = '0;
        cnt      = rec.count;
        unique case (kind)
            KIND_WAIT:
            begin
                // saturating decrement, block when negative
                if (rec.count != CNT_MIN)
                begin
                    cnt = rec.count - CNT_ONE;
                end
                rec_next.count = cnt;
                if (cnt[CNT_W-1])
                begin
                    if (rec.nonempty)
                    begin
                        upd.link_write = 1'b1;
                    end
                    else
                    begin
                        rec_next.head     = task_id;
                        rec_next.nonempty = 1'b1;
                    end
                    rec_next.tail = task_id;
                end
                else
                begin
                    upd.proceed = 1'b1;
                end
            end
            KIND_SIGNAL:
            begin
                // saturating increment, release head while count <= 0
                if (rec.count != CNT_MAX)
                begin
                    cnt = rec.count + CNT_ONE;
                end
                rec_next.count = cnt;
                if ((cnt[CNT_W-1] || cnt == '0) && rec.nonempty)
                begin
                    upd.wake = 1'b1;
                    if (rec.head == rec.tail)
                    begin
                        rec_next.nonempty = 1'b0;
                    end
                    else
                    begin
                        upd.need_link = 1'b1;
                        rec_next.head = link_head;
                    end
                end
            end
            KIND_ALLOC, KIND_FREE:
            begin
                // handled by the sequencer
            end
        endcase
    end

endmodule
